// ----- rtl/sali_pkg.sv -----
`default_nettype none
package sali_pkg;

  localparam int FRAC_BITS    = 8;
  localparam int POS_INT_BITS = 15;
  localparam int POS_W        = POS_INT_BITS + FRAC_BITS;
  localparam int DIFF_W       = POS_W + 1;
  localparam int BIT_CNT_W    = $clog2(DIFF_W);
  localparam int NUM_AXES     = 6;
  localparam int MAX_STEPS    = 64;
  localparam int CNT_W        = 7;
  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;
  localparam int REG_IDX_W    = ADDR_W - 2;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CNT_W-1:0]     STEP_COUNT_RESET = CNT_W'(50);
  localparam logic [REG_IDX_W-1:0] REG_STEP_COUNT   = REG_IDX_W'(0);

  typedef logic [POS_INT_BITS-1:0] pulse_t;
  typedef pulse_t [NUM_AXES-1:0] pulse_vec_t;

  typedef struct packed {
    pulse_t target_axis0;
    pulse_t target_axis1;
    pulse_t target_axis2;
    pulse_t target_axis3;
    pulse_t target_axis4;
    pulse_t target_axis5;
  } in_item_t;

  typedef struct packed {
    pulse_t pos_axis0;
    pulse_t pos_axis1;
    pulse_t pos_axis2;
    pulse_t pos_axis3;
    pulse_t pos_axis4;
    pulse_t pos_axis5;
    logic   last_step;
  } out_item_t;

  // Move command as queued between front and back
  typedef struct packed {
    pulse_vec_t       target;
    logic [CNT_W-1:0] count;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ABS,
    S_DIV,
    S_FIX,
    S_EMIT
  } back_state_t;

  function automatic pulse_t home_pos(input int unsigned axis);
    pulse_t p;
    case (axis)
      0:       p = POS_INT_BITS'(1200);
      1:       p = POS_INT_BITS'(950);
      2:       p = POS_INT_BITS'(1350);
      3:       p = POS_INT_BITS'(1800);
      default: p = POS_INT_BITS'(1500);
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/sali_queue.sv -----
`default_nettype none
module sali_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire sali_pkg::cmd_t push_data,
  output logic               full,
  input  wire logic          pop,
  output sali_pkg::cmd_t     pop_data,
  output logic               empty
);

  sali_pkg::cmd_t mem [sali_pkg::QUEUE_DEPTH];
  logic [sali_pkg::QPTR_W-1:0] wr_ptr;
  logic [sali_pkg::QPTR_W-1:0] rd_ptr;
  logic [sali_pkg::QCNT_W-1:0] count;

  assign full     = (count == sali_pkg::QCNT_W'(sali_pkg::QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sali_front.sv -----
`default_nettype none
module sali_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sali_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [sali_pkg::DATA_W-1:0]   pwdata,
  output logic [sali_pkg::DATA_W-1:0]        prdata,
  output logic                               pready,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire sali_pkg::in_item_t            in_data,
  output logic                               push,
  output sali_pkg::cmd_t                     push_data,
  input  wire logic                          q_full
);

  logic [sali_pkg::CNT_W-1:0]     step_count;
  logic [sali_pkg::CNT_W-1:0]     eff_count;
  logic [sali_pkg::REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[sali_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count <= sali_pkg::STEP_COUNT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 reg_idx == sali_pkg::REG_STEP_COUNT) begin
      step_count <= pwdata[sali_pkg::CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == sali_pkg::REG_STEP_COUNT) begin
      prdata = sali_pkg::DATA_W'(step_count);
    end
  end

  // Zero count acts as one, large counts saturate
  always_comb begin
    if (step_count == '0) begin
      eff_count = sali_pkg::CNT_W'(1);
    end else if (step_count > sali_pkg::CNT_W'(sali_pkg::MAX_STEPS)) begin
      eff_count = sali_pkg::CNT_W'(sali_pkg::MAX_STEPS);
    end else begin
      eff_count = step_count;
    end
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_data.count     = eff_count;
    push_data.target[0] = in_data.target_axis0;
    push_data.target[1] = in_data.target_axis1;
    push_data.target[2] = in_data.target_axis2;
    push_data.target[3] = in_data.target_axis3;
    push_data.target[4] = in_data.target_axis4;
    push_data.target[5] = in_data.target_axis5;
  end

endmodule
`default_nettype wire

// ----- rtl/sali_back.sv -----
`default_nettype none
module sali_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sali_pkg::cmd_t     q_data,
  input  wire logic               q_empty,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output sali_pkg::out_item_t     out_data
);

  localparam int FB = sali_pkg::FRAC_BITS;
  localparam int PW = sali_pkg::POS_W;
  localparam int DW = sali_pkg::DIFF_W;
  localparam int CW = sali_pkg::CNT_W;
  localparam int NA = sali_pkg::NUM_AXES;

  sali_pkg::back_state_t state, state_next;

  logic [DW-1:0]        dvd   [NA];  // difference, then magnitude, then quotient
  logic [CW-1:0]        rem   [NA];
  logic                 neg   [NA];
  logic [DW-1:0]        delta [NA];
  logic [PW-1:0]        cur   [NA];
  sali_pkg::pulse_t     tgt   [NA];
  logic [CW-1:0]        n;
  logic [CW-1:0]        step;
  logic [sali_pkg::BIT_CNT_W-1:0] bit_cnt;

  logic [DW-1:0]        diff     [NA];
  logic [CW:0]          shifted  [NA];
  logic                 ge       [NA];
  logic [CW-1:0]        rem_next [NA];
  logic signed [DW:0]   sum      [NA];
  logic [PW-1:0]        new_pos  [NA];

  logic emit;
  logic last;

  assign last = (step == n - 1'b1);

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      diff[a]     = {1'b0, q_data.target[a], {FB{1'b0}}} - {1'b0, cur[a]};
      shifted[a]  = {rem[a], dvd[a][DW-1]};
      ge[a]       = (shifted[a] >= {1'b0, n});
      rem_next[a] = ge[a] ? CW'(shifted[a] - {1'b0, n}) : shifted[a][CW-1:0];
      sum[a]      = $signed({2'b00, cur[a]}) + $signed({delta[a][DW-1], delta[a]});
      // Zero step snaps to target; otherwise add and saturate
      if (delta[a] == '0) begin
        new_pos[a] = {tgt[a], {FB{1'b0}}};
      end else if (sum[a][DW]) begin
        new_pos[a] = '0;
      end else if (sum[a][DW-1]) begin
        new_pos[a] = '1;
      end else begin
        new_pos[a] = sum[a][PW-1:0];
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sali_pkg::S_IDLE: if (!q_empty) state_next = sali_pkg::S_ABS;
      sali_pkg::S_ABS:  state_next = sali_pkg::S_DIV;
      sali_pkg::S_DIV:  if (bit_cnt == '0) state_next = sali_pkg::S_FIX;
      sali_pkg::S_FIX:  state_next = sali_pkg::S_EMIT;
      sali_pkg::S_EMIT: if (emit && last) state_next = sali_pkg::S_IDLE;
      default:          state_next = sali_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    pop  = 1'b0;
    emit = 1'b0;
    unique case (state)
      sali_pkg::S_IDLE: pop  = !q_empty;
      sali_pkg::S_EMIT: emit = !out_valid || !out_stall;
      default: begin
        pop  = 1'b0;
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sali_pkg::S_IDLE;
      out_valid <= 1'b0;
      for (int a = 0; a < NA; a++) begin
        cur[a] <= {sali_pkg::home_pos(a), {FB{1'b0}}};
      end
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
        for (int a = 0; a < NA; a++) begin
          cur[a] <= new_pos[a];
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      sali_pkg::S_IDLE: begin
        if (pop) begin
          n       <= q_data.count;
          step    <= '0;
          bit_cnt <= sali_pkg::BIT_CNT_W'(DW - 1);
          for (int a = 0; a < NA; a++) begin
            tgt[a] <= q_data.target[a];
            dvd[a] <= diff[a];
          end
        end
      end
      sali_pkg::S_ABS: begin
        for (int a = 0; a < NA; a++) begin
          neg[a] <= dvd[a][DW-1];
          dvd[a] <= dvd[a][DW-1] ? -dvd[a] : dvd[a];
          rem[a] <= '0;
        end
      end
      sali_pkg::S_DIV: begin
        bit_cnt <= bit_cnt - 1'b1;
        for (int a = 0; a < NA; a++) begin
          dvd[a] <= {dvd[a][DW-2:0], ge[a]};
          rem[a] <= rem_next[a];
        end
      end
      sali_pkg::S_FIX: begin
        for (int a = 0; a < NA; a++) begin
          delta[a] <= neg[a] ? -dvd[a] : dvd[a];
        end
      end
      sali_pkg::S_EMIT: begin
        if (emit) begin
          step               <= step + 1'b1;
          out_data.pos_axis0 <= new_pos[0][PW-1:FB];
          out_data.pos_axis1 <= new_pos[1][PW-1:FB];
          out_data.pos_axis2 <= new_pos[2][PW-1:FB];
          out_data.pos_axis3 <= new_pos[3][PW-1:FB];
          out_data.pos_axis4 <= new_pos[4][PW-1:FB];
          out_data.pos_axis5 <= new_pos[5][PW-1:FB];
          out_data.last_step <= last;
        end
      end
      default: begin
        step <= step;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/six_axis_linear_interpolator.sv -----
`default_nettype none
// Six-axis linear interpolator. Each input item is a move command with six
// target pulse widths; the block answers with step_count result items, each
// holding the integer parts of the six interpolated positions, the final one
// flagged by last_step. Per axis the step is (target - current) / step_count
// in fixed point with 8 fraction bits, truncated toward zero; an axis whose
// step is zero jumps to its target on the first result. step_count (APB
// address 0, reset 50) counts 0 as 1 and saturates above 64; write it only
// while the block is idle. Positions start at 1200, 950, 1350, 1800, 1500,
// 1500 after reset. Back end sequence per command: load it, take
// magnitudes, run the bit-serial dividers (one quotient bit per cycle,
// six lanes in parallel), fix the sign, then emit one result per cycle
// while the output is not stalled. A two-entry command queue lets the
// input side take up to two commands ahead while the back end works.
module six_axis_linear_interpolator (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sali_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [sali_pkg::DATA_W-1:0]   pwdata,
  output logic [sali_pkg::DATA_W-1:0]        prdata,
  output logic                               pready,
  // move commands
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire sali_pkg::in_item_t            in_data,
  // interpolated positions
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output sali_pkg::out_item_t                out_data
);

  sali_pkg::cmd_t push_data;
  sali_pkg::cmd_t pop_data;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;

  // Front: register port, count clamp, accept commands into the queue
  sali_front u_front (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  // Hold pending commands so each side can stall on its own
  sali_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  // Back: divide, then advance positions one step per result item
  sali_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_data    (pop_data),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
